@@ rtl/distinct_value_frequency_counter_top_defines.svh @@
// Assertion macros shared by the RTL of the distinct value frequency counter.
// Clock i_clk and active-low reset i_rst_n are assumed in the enclosing module.
`ifndef DISTINCT_VALUE_FREQUENCY_COUNTER_TOP_DEFINES_SVH
`define DISTINCT_VALUE_FREQUENCY_COUNTER_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define DVFC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the following cycle
`define DVFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/dvfc_pkg.sv @@
`timescale 1ns / 1ps

package dvfc_pkg;

    localparam int DEF_TABLE_ENTRIES = 32;
    localparam int VALUE_W           = 32;
    localparam int COUNT_W           = 31;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_ONE = {{(COUNT_W-1){1'b0}}, 1'b1};

    typedef enum logic {
        ST_COLLECT,
        ST_EMIT
    } t_state;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic load;     // input transfer this cycle
        logic any_hit;  // some cell matched the incoming value
        logic shift;    // output transfer: every cell takes its upper neighbor
    } t_cell_ctrl;

endpackage

@@ rtl/dvfc_cell.sv @@
`timescale 1ns / 1ps

module dvfc_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dvfc_pkg::t_cell_ctrl              i_ctrl,
    input  logic [dvfc_pkg::VALUE_W-1:0]      i_value,
    input  logic                              i_prev_used,
    input  logic                              i_next_used,
    input  logic [dvfc_pkg::VALUE_W-1:0]      i_next_value,
    input  logic [dvfc_pkg::COUNT_W-1:0]      i_next_count,
    output logic                              o_hit,
    output logic                              o_used,
    output logic [dvfc_pkg::VALUE_W-1:0]      o_value,
    output logic [dvfc_pkg::COUNT_W-1:0]      o_count
);

    logic                         r_used;
    logic [dvfc_pkg::VALUE_W-1:0] r_value;
    logic [dvfc_pkg::COUNT_W-1:0] r_count;
    logic                         w_claim;

    assign o_hit   = r_used && (r_value == i_value);
    // first free cell takes a value no cell holds
    assign w_claim = !i_ctrl.any_hit && !r_used && i_prev_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else if (i_ctrl.shift) begin
            r_used <= i_next_used;
        end else if (i_ctrl.load && w_claim) begin
            r_used <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_value <= i_next_value;
            r_count <= i_next_count;
        end else if (i_ctrl.load) begin
            if (o_hit) begin
                if (r_count != dvfc_pkg::COUNT_MAX) begin
                    r_count <= r_count + dvfc_pkg::COUNT_ONE;
                end
            end else if (w_claim) begin
                r_value <= i_value;
                r_count <= dvfc_pkg::COUNT_ONE;
            end
        end
    end

    assign o_used  = r_used;
    assign o_value = r_value;
    assign o_count = r_count;

endmodule

@@ rtl/distinct_value_frequency_counter_top.sv @@
`timescale 1ns / 1ps
// Distinct value frequency counter.
// Input channel (i_valid / o_stall): one array element per transfer, i_value,
// with i_last_element high on the final element of the array.
// Output channel (o_valid / i_stall): one (value, count) pair per transfer, in
// order of first appearance; o_final_pair marks the last pair, and
// o_table_overflow is high on every pair if a new value was dropped because
// all TABLE_ENTRIES cells were taken.
// Throughput: while collecting, one element per cycle; every cell compares
// its entry against the broadcast value in the same cycle, so the match is
// one wide compare per cell plus an OR across the row.
// The first pair is valid the cycle after the last element's
// transfer. Emission then sends one pair per stored entry (1 to
// TABLE_ENTRIES), as the row shifts toward cell 0 one entry per output
// transfer; o_stall is high during the whole emission.
// A stalled output simply freezes the row; the pair on the ports holds.
// Reset marks every cell empty and clears the overflow flag; no clearing
// pass is needed, and the shift out leaves the row empty for the next array.
`include "distinct_value_frequency_counter_top_defines.svh"

module distinct_value_frequency_counter_top #(
    parameter int TABLE_ENTRIES = dvfc_pkg::DEF_TABLE_ENTRIES
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [dvfc_pkg::VALUE_W-1:0]  i_value,
    input  logic                                 i_last_element,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [dvfc_pkg::VALUE_W-1:0]  o_distinct_value,
    output logic        [dvfc_pkg::COUNT_W-1:0]  o_occurrences,
    output logic                                 o_final_pair,
    output logic                                 o_table_overflow
);

    dvfc_pkg::t_state     r_state, n_state;
    logic                 r_ovf, n_ovf;
    dvfc_pkg::t_cell_ctrl w_ctrl;

    logic                         w_in_xfer;
    logic                         w_out_xfer;
    logic [TABLE_ENTRIES-1:0]     w_hit;
    logic [TABLE_ENTRIES-1:0]     w_used;
    logic [TABLE_ENTRIES-1:0]     w_used_inc;
    // one extra slot above the top cell reads as empty during the shift
    logic [TABLE_ENTRIES:0]       w_used_ext;
    logic [TABLE_ENTRIES:0]       w_used_prev;
    logic [dvfc_pkg::VALUE_W-1:0] w_val [0:TABLE_ENTRIES];
    logic [dvfc_pkg::COUNT_W-1:0] w_cnt [0:TABLE_ENTRIES];
    logic                         w_drop;

    assign w_in_xfer  = i_valid && !o_stall;
    assign w_out_xfer = o_valid && !i_stall;

    assign w_ctrl.load    = w_in_xfer;
    assign w_ctrl.any_hit = |w_hit;
    assign w_ctrl.shift   = w_out_xfer;

    assign w_used_ext  = {1'b0, w_used};
    assign w_used_prev = {w_used, 1'b1};
    assign w_used_inc  = w_used + {{(TABLE_ENTRIES-1){1'b0}}, 1'b1};
    assign w_val[TABLE_ENTRIES] = '0;
    assign w_cnt[TABLE_ENTRIES] = '0;

    // new value with every cell taken and none matching
    assign w_drop = w_in_xfer && !w_ctrl.any_hit && w_used[TABLE_ENTRIES-1];

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        dvfc_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_value      (i_value),
            .i_prev_used  (w_used_prev[g]),
            .i_next_used  (w_used_ext[g+1]),
            .i_next_value (w_val[g+1]),
            .i_next_count (w_cnt[g+1]),
            .o_hit        (w_hit[g]),
            .o_used       (w_used[g]),
            .o_value      (w_val[g]),
            .o_count      (w_cnt[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dvfc_pkg::ST_COLLECT;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovf   <= n_ovf;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ovf   = r_ovf;
        o_stall = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            dvfc_pkg::ST_COLLECT: begin
                if (w_drop) begin
                    n_ovf = 1'b1;
                end
                if (w_in_xfer && i_last_element) begin
                    n_state = dvfc_pkg::ST_EMIT;
                end
            end
            dvfc_pkg::ST_EMIT: begin
                o_stall = 1'b1;
                o_valid = 1'b1;
                if (w_out_xfer && o_final_pair) begin
                    n_state = dvfc_pkg::ST_COLLECT;
                    n_ovf   = 1'b0;
                end
            end
            default: begin
                n_state = dvfc_pkg::ST_COLLECT;
            end
        endcase
    end

    // cell 0 always holds the next pair to send
    assign o_distinct_value = w_val[0];
    assign o_occurrences    = w_cnt[0];
    assign o_final_pair     = w_used_ext[0] && !w_used_ext[1];
    assign o_table_overflow = r_ovf;

    `DVFC_ASSERT_IMPL(a_hit_unique, w_in_xfer, $onehot0(w_hit), "two cells hold one value")
    `DVFC_ASSERT_IMPL(a_used_packed, 1'b1, (w_used & w_used_inc) == '0, "cell row has a gap")
    `DVFC_ASSERT_IMPL(a_emit_nonempty, r_state == dvfc_pkg::ST_EMIT, w_used[0],
        "emission with empty row")
    `DVFC_ASSERT_NEXT(a_final_clears, w_out_xfer && o_final_pair, (w_used == '0) && !r_ovf,
        "row not empty after final pair")
    `DVFC_ASSERT_IMPL(a_ovf_when_full, $rose(r_ovf), &w_used, "overflow with free cell")

endmodule

@@ sim/distinct_value_frequency_counter_top_tb.sv @@
`timescale 1ns / 1ps

module distinct_value_frequency_counter_top_tb;

    localparam int TABLE_ENTRIES = dvfc_pkg::DEF_TABLE_ENTRIES;
    localparam int TOTAL_ITEMS   = 430;
    localparam int PHASE_ITEMS   = 145;   // elements per idling phase
    localparam int QUIET_LIMIT   = 2000;  // cycles with no transfer on either side

    // one (value, count) pair as the output channel carries it
    typedef struct packed {
        logic signed [dvfc_pkg::VALUE_W-1:0] value;
        logic        [dvfc_pkg::COUNT_W-1:0] count;
        logic                                final_pair;
        logic                                overflow;
    } t_pair;

    // directed stimulus row; typed rows carry their own expected count
    typedef struct packed {
        logic [dvfc_pkg::VALUE_W-1:0] value;
        logic                         last;
        logic                         typed;
        logic [dvfc_pkg::COUNT_W-1:0] count;
    } t_row;

    logic                                i_clk;
    logic                                i_rst_n        = 1'b0;
    logic                                i_valid        = 1'b0;
    logic                                o_stall;
    logic signed [dvfc_pkg::VALUE_W-1:0] i_value        = '0;
    logic                                i_last_element = 1'b0;
    logic                                o_valid;
    logic                                i_stall        = 1'b0;
    logic signed [dvfc_pkg::VALUE_W-1:0] o_distinct_value;
    logic        [dvfc_pkg::COUNT_W-1:0] o_occurrences;
    logic                                o_final_pair;
    logic                                o_table_overflow;

    int    idle_pct     = 35;
    int    stall_pct    = 72;
    int    errors       = 0;
    int    quiet_cycles = 0;

    // hand-written expectation riding along with the element on the port
    logic  typed_on     = 1'b0;
    t_pair typed_pair   = '0;

    // predictor copy of the count table
    logic [dvfc_pkg::VALUE_W-1:0] seen_values [TABLE_ENTRIES];
    logic [dvfc_pkg::COUNT_W-1:0] seen_counts [TABLE_ENTRIES];
    int                           n_seen  = 0;
    logic                         dropped = 1'b0;
    t_pair                        pending_pairs [$];

    distinct_value_frequency_counter_top #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_value          (i_value),
        .i_last_element   (i_last_element),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_distinct_value (o_distinct_value),
        .o_occurrences    (o_occurrences),
        .o_final_pair     (o_final_pair),
        .o_table_overflow (o_table_overflow)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Count one element; on the last one, queue every entry in insertion order
    // (only the hand pair for a typed row) and empty the table. Saturation needs
    // 2^31 - 1 occurrences, far beyond any run, but is kept so the predictor stays exact.
    function automatic void tally_element(logic [dvfc_pkg::VALUE_W-1:0] v, logic last,
                                          logic hand, t_pair hand_pair);
        int    hit;
        t_pair p;
        hit = -1;
        for (int i = 0; i < n_seen; i++) begin
            if (hit < 0 && seen_values[i] == v) hit = i;
        end
        if (hit >= 0) begin
            if (seen_counts[hit] != dvfc_pkg::COUNT_MAX) seen_counts[hit] += 1'b1;
        end else if (n_seen < TABLE_ENTRIES) begin
            seen_values[n_seen] = v;
            seen_counts[n_seen] = dvfc_pkg::COUNT_ONE;
            n_seen++;
        end else begin
            dropped = 1'b1;   // table full: new value lost
        end
        if (last) begin
            if (hand) begin
                pending_pairs.push_back(hand_pair);
            end else begin
                for (int i = 0; i < n_seen; i++) begin
                    p.value      = seen_values[i];
                    p.count      = seen_counts[i];
                    p.final_pair = (i == n_seen - 1);
                    p.overflow   = dropped;
                    pending_pairs.push_back(p);
                end
            end
            n_seen  = 0;
            dropped = 1'b0;
        end
    endfunction

    // random word with the field extremes mixed in
    function automatic logic [dvfc_pkg::VALUE_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4:       return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    // Idle cycles put junk on the payload so only the valid qualifies it.
    task automatic send_element(input logic [dvfc_pkg::VALUE_W-1:0] value,
                                input logic last, input logic typed,
                                input logic [dvfc_pkg::COUNT_W-1:0] count);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_valid        <= 1'b0;
            i_value        <= $urandom;
            i_last_element <= 1'($urandom_range(0, 1));
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_value        <= value;
        i_last_element <= last;
        typed_on       <= typed;
        typed_pair     <= '{value, count, 1'b1, 1'b0};
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    // output side back-pressure, redrawn every cycle
    initial begin : receiver
        forever begin
            @(negedge i_clk);
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // transfers on both channels: predict on input, check on output
    always @(posedge i_clk) begin : monitor
        t_pair want;
        if (i_rst_n) begin
            quiet_cycles++;
            if (i_valid && !o_stall) begin
                tally_element(i_value, i_last_element, typed_on, typed_pair);
                quiet_cycles = 0;
            end
            if (o_valid && !i_stall) begin
                quiet_cycles = 0;
                if (pending_pairs.size() == 0) begin
                    $display("%0t: pair with nothing pending: value %0d count %0d",
                             $time, o_distinct_value, o_occurrences);
                    errors++;
                end else begin
                    want = pending_pairs.pop_front();
                    if (o_distinct_value !== want.value) begin
                        $display("%0t: distinct_value expected %0d got %0d",
                                 $time, want.value, o_distinct_value);
                        errors++;
                    end
                    if (o_occurrences !== want.count) begin
                        $display("%0t: occurrences expected %0d got %0d",
                                 $time, want.count, o_occurrences);
                        errors++;
                    end
                    if (o_final_pair !== want.final_pair) begin
                        $display("%0t: final_pair expected %0b got %0b",
                                 $time, want.final_pair, o_final_pair);
                        errors++;
                    end
                    if (o_table_overflow !== want.overflow) begin
                        $display("%0t: table_overflow expected %0b got %0b",
                                 $time, want.overflow, o_table_overflow);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        t_row                         rows [0:21];
        logic [dvfc_pkg::VALUE_W-1:0] pool [$];
        logic [dvfc_pkg::VALUE_W-1:0] v;
        int                           sent;
        int                           kind;
        int                           len;
        int                           pool_n;
        int                           phase;

        rows = '{
            // one-element arrays at the extremes
            '{32'h8000_0000, 1'b1, 1'b1, 31'd1},
            '{32'h7FFF_FFFF, 1'b1, 1'b1, 31'd1},
            '{32'h0000_0000, 1'b1, 1'b1, 31'd1},
            '{32'hFFFF_FFFF, 1'b1, 1'b1, 31'd1},
            // repeat on the last element
            '{32'd5,         1'b0, 1'b0, 31'd0},
            '{32'd5,         1'b1, 1'b1, 31'd2},
            // mixed signs, last element hits an existing entry
            '{32'd3,         1'b0, 1'b0, 31'd0},
            '{32'hFFFF_FFFD, 1'b0, 1'b0, 31'd0},
            '{32'd3,         1'b0, 1'b0, 31'd0},
            '{32'h7FFF_FFFF, 1'b0, 1'b0, 31'd0},
            '{32'hFFFF_FFFD, 1'b0, 1'b0, 31'd0},
            '{32'd3,         1'b1, 1'b0, 31'd0},
            // alternating bit patterns and the lone sign bit
            '{32'hAAAA_AAAA, 1'b0, 1'b0, 31'd0},
            '{32'h5555_5555, 1'b0, 1'b0, 31'd0},
            '{32'h8000_0000, 1'b0, 1'b0, 31'd0},
            '{32'h5555_5555, 1'b1, 1'b0, 31'd0},
            // new value on the last element
            '{32'd1,         1'b0, 1'b0, 31'd0},
            '{32'd2,         1'b0, 1'b0, 31'd0},
            '{32'd3,         1'b1, 1'b0, 31'd0},
            // one value three times
            '{32'h1234_5678, 1'b0, 1'b0, 31'd0},
            '{32'h1234_5678, 1'b0, 1'b0, 31'd0},
            '{32'h1234_5678, 1'b1, 1'b1, 31'd3}
        };

        phase = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        sent = 0;
        foreach (rows[r]) begin
            send_element(rows[r].value, rows[r].last, rows[r].typed, rows[r].count);
            sent++;
        end

        while (sent < TOTAL_ITEMS) begin
            // phase change: hold the input off until the last array is drained
            if (phase < 2 && sent >= (phase + 1) * PHASE_ITEMS) begin
                i_valid <= 1'b0;
                do @(negedge i_clk); while (pending_pairs.size() != 0);
                phase++;
                idle_pct  = (phase == 1) ? 72 : 0;
                stall_pct = (phase == 1) ? 35 : 0;
            end

            kind = $urandom_range(0, 99);
            if (kind < 60) begin
                // short array, small pool so values repeat
                pool_n = $urandom_range(1, 6);
                len    = $urandom_range(1, 12);
            end else if (kind < 75) begin
                pool_n = $urandom_range(1, 20);
                len    = $urandom_range(13, 30);
            end else if (kind < 90) begin
                // around a full table: each pool value once, then repeats
                pool_n = $urandom_range(31, 40);
                len    = pool_n + $urandom_range(0, 8);
            end else begin
                pool_n = 0;   // noise: every element fresh
                len    = $urandom_range(1, 6);
            end

            pool.delete();
            for (int i = 0; i < pool_n; i++) pool.push_back(pick_word());

            for (int k = 0; k < len; k++) begin
                if (pool_n == 0)
                    v = $urandom;
                else if (kind >= 75 && k < pool_n)
                    v = pool[k];
                else
                    v = pool[$urandom_range(0, pool_n - 1)];
                send_element(v, (k == len - 1), 1'b0, '0);
                sent++;
            end
        end

        i_valid <= 1'b0;
        while (pending_pairs.size() != 0) @(posedge i_clk);
        // room for any stray pair past the last expected one
        repeat (TABLE_ENTRIES + 8) @(posedge i_clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
